// ===== hdl/cie_pkg.sv =====
// Shared types and constants for the 16-bit instruction execute block.
`timescale 1ns / 1ps

package cie_pkg;

   // Architectural sizes
   localparam int WORD_W     = 16;
   localparam int PC_W       = 8;
   localparam int REG_COUNT  = 8;
   localparam int REG_ADDR_W = 3;
   localparam int MEM_DEPTH  = 256;
   localparam int MEM_ADDR_W = 8;

   // Instruction field positions
   localparam int OPC_MSB = 15;
   localparam int OPC_LSB = 11;
   localparam int RA_MSB  = 10;
   localparam int RA_LSB  = 8;
   localparam int RB_MSB  = 7;
   localparam int RB_LSB  = 5;
   localparam int IMM_MSB = 7;

   typedef enum logic [4:0] {
      OP_MOV = 5'd0,
      OP_ADD = 5'd1,
      OP_SUB = 5'd2,
      OP_AND = 5'd3,
      OP_OR  = 5'd4,
      OP_SL  = 5'd5,
      OP_SR  = 5'd6,
      OP_SRA = 5'd7,
      OP_LDL = 5'd8,
      OP_LDH = 5'd9,
      OP_CMP = 5'd10,
      OP_JE  = 5'd11,
      OP_JMP = 5'd12,
      OP_LD  = 5'd13,
      OP_ST  = 5'd14,
      OP_HLT = 5'd15
   } opcode_type;

   // Architectural state seen by the execute logic
   typedef struct packed {
      logic [PC_W-1:0] pc;
      logic            equal;
      logic            stopped;
   } arch_state_type;

   // Everything one executed instruction produces
   typedef struct packed {
      logic [PC_W-1:0]       next_pc;
      logic                  halted;
      logic                  equal_flag;
      logic                  reg_write;
      logic [REG_ADDR_W-1:0] reg_index;
      logic [WORD_W-1:0]     reg_value;
      logic                  mem_write;
      logic [MEM_ADDR_W-1:0] mem_addr;
      logic [WORD_W-1:0]     mem_data;
   } exec_result_type;

endpackage

// ===== hdl/cie_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cie_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read returns old data on a collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cie_alu.sv =====
// Execute logic: decodes one instruction and computes its effects.
`timescale 1ns / 1ps

module cie_alu import cie_pkg::*; (
   input  logic [WORD_W-1:0] instruction,
   input  logic [WORD_W-1:0] opnd_a,
   input  logic [WORD_W-1:0] opnd_b,
   input  logic [WORD_W-1:0] mem_word,
   input  arch_state_type    state,
   output exec_result_type   result
);

   opcode_type            opc;
   logic [REG_ADDR_W-1:0] ra;
   logic [MEM_ADDR_W-1:0] imm;

   assign opc = opcode_type'(instruction[OPC_MSB:OPC_LSB]);
   assign ra  = instruction[RA_MSB:RA_LSB];
   assign imm = instruction[IMM_MSB:0];

   // Compute next counter, flags and the register or memory write
   always_comb begin
      result            = '0;
      result.next_pc    = state.pc;
      result.halted     = state.stopped;
      result.equal_flag = state.equal;
      if (!state.stopped) begin
         result.next_pc = PC_W'(state.pc + 8'd1);
         case (opc)
            OP_MOV: begin
               result.reg_write = 1'b1;
               result.reg_value = opnd_b;
            end
            OP_ADD: begin
               result.reg_write = 1'b1;
               result.reg_value = WORD_W'(opnd_a + opnd_b);
            end
            OP_SUB: begin
               result.reg_write = 1'b1;
               result.reg_value = WORD_W'(opnd_a - opnd_b);
            end
            OP_AND: begin
               result.reg_write = 1'b1;
               result.reg_value = opnd_a & opnd_b;
            end
            OP_OR: begin
               result.reg_write = 1'b1;
               result.reg_value = opnd_a | opnd_b;
            end
            OP_SL: begin
               result.reg_write = 1'b1;
               result.reg_value = {opnd_a[WORD_W-2:0], 1'b0};
            end
            OP_SR: begin
               result.reg_write = 1'b1;
               result.reg_value = {1'b0, opnd_a[WORD_W-1:1]};
            end
            OP_SRA: begin
               result.reg_write = 1'b1;
               result.reg_value = {opnd_a[WORD_W-1], opnd_a[WORD_W-1:1]};
            end
            OP_LDL: begin
               result.reg_write = 1'b1;
               result.reg_value = {opnd_a[WORD_W-1:8], imm};
            end
            OP_LDH: begin
               result.reg_write = 1'b1;
               result.reg_value = {imm, opnd_a[7:0]};
            end
            OP_CMP: begin
               result.equal_flag = (opnd_a == opnd_b);
            end
            OP_JE: begin
               if (state.equal) begin
                  result.next_pc = imm;
               end
            end
            OP_JMP: begin
               result.next_pc = imm;
            end
            OP_LD: begin
               result.reg_write = 1'b1;
               result.reg_value = mem_word;
            end
            OP_ST: begin
               result.mem_write = 1'b1;
               result.mem_addr  = imm;
               result.mem_data  = opnd_a;
            end
            OP_HLT: begin
               result.halted = 1'b1;
            end
            default: begin
               // unused opcodes only advance the counter
            end
         endcase
         if (result.reg_write) begin
            result.reg_index = ra;
         end
      end
   end

endmodule

// ===== hdl/cpu16_instruction_execute.sv =====
// Top level of the 16-bit instruction execute block.
// Usage:
//   The req_ channel carries one instruction word per transaction, the word
//   fetched at the program counter last reported on rsp_next_pc. The rsp_
//   channel returns one transaction per instruction: the new counter, the
//   halted and equal flags, and any register or data memory write.
// Pipeline and throughput:
//   An accepted transaction goes to the input register and its result to the
//   output register. One instruction is accepted every cycle unless stalled.
//   At acceptance the register file copies and the data memory are read; a
//   write by the instruction executing in that same cycle is forwarded.
//   The execute stage then computes the result into the output register.
// Stall:
//   While rsp_stall holds a result, the instruction behind it waits in the
//   input register, and req_stall rises only once that register is full.
// Reset:
//   Synchronous reset empties both stages, clears the counter, equal flag
//   and halted mark, and marks every register and memory word as zero.
//   No clearing pass is needed; the block accepts work in the next cycle.
// After halt, instructions are still taken and answered with held state.
`timescale 1ns / 1ps

module cpu16_instruction_execute import cie_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [WORD_W-1:0]     req_instruction,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PC_W-1:0]       rsp_next_pc,
   output logic                  rsp_halted,
   output logic                  rsp_equal_flag,
   output logic                  rsp_reg_write,
   output logic [REG_ADDR_W-1:0] rsp_reg_index,
   output logic [WORD_W-1:0]     rsp_reg_value,
   output logic                  rsp_mem_write,
   output logic [MEM_ADDR_W-1:0] rsp_mem_addr,
   output logic [WORD_W-1:0]     rsp_mem_data
);

   // Control state
   logic                 s1_valid_ff;
   logic                 rsp_valid_ff;
   logic [PC_W-1:0]      pc_ff;
   logic                 flag_ff;
   logic                 stop_ff;
   logic [REG_COUNT-1:0] reg_vld_ff;
   logic [MEM_DEPTH-1:0] mem_vld_ff;

   // Input stage payload
   logic [WORD_W-1:0] s1_instr_ff;
   logic              s1_a_byp_ff, s1_b_byp_ff, s1_m_byp_ff;
   logic [WORD_W-1:0] s1_a_fwd_ff, s1_b_fwd_ff, s1_m_fwd_ff;
   logic              s1_a_vld_ff, s1_b_vld_ff, s1_m_vld_ff;

   // Output register payload
   exec_result_type rsp_res_ff;

   logic                  accept;
   logic                  exec_fire;
   logic                  out_free;
   logic                  reg_we;
   logic                  mem_we;
   logic [REG_ADDR_W-1:0] in_ra, in_rb;
   logic [MEM_ADDR_W-1:0] in_addr;
   logic [WORD_W-1:0]     ra_data, rb_data, mem_rd_data;
   logic [WORD_W-1:0]     opnd_a, opnd_b, mem_word;
   logic                  a_byp_in, b_byp_in, m_byp_in;
   arch_state_type        state;
   exec_result_type       res;

   // Handshake and stage advance
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign exec_fire = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !exec_fire;
   assign accept    = req_valid && !req_stall;

   assign in_ra   = req_instruction[RA_MSB:RA_LSB];
   assign in_rb   = req_instruction[RB_MSB:RB_LSB];
   assign in_addr = req_instruction[IMM_MSB:0];

   assign reg_we = exec_fire && res.reg_write;
   assign mem_we = exec_fire && res.mem_write;

   // Forward writes of the executing instruction to the incoming one
   assign a_byp_in = reg_we && (res.reg_index == in_ra);
   assign b_byp_in = reg_we && (res.reg_index == in_rb);
   assign m_byp_in = mem_we && (res.mem_addr == in_addr);

   // Register file: two copies give two read ports
   cie_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
      .clock   (clock),
      .wr_en   (reg_we),
      .wr_addr (res.reg_index),
      .wr_data (res.reg_value),
      .rd_en   (accept),
      .rd_addr (in_ra),
      .rd_data (ra_data)
   );

   cie_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
      .clock   (clock),
      .wr_en   (reg_we),
      .wr_addr (res.reg_index),
      .wr_data (res.reg_value),
      .rd_en   (accept),
      .rd_addr (in_rb),
      .rd_data (rb_data)
   );

   // Data memory
   cie_ram #(.WIDTH(WORD_W), .DEPTH(MEM_DEPTH)) u_dmem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (res.mem_addr),
      .wr_data (res.mem_data),
      .rd_en   (accept),
      .rd_addr (in_addr),
      .rd_data (mem_rd_data)
   );

   // Select operands: forwarded value, stored word, or zero if never written
   assign opnd_a   = s1_a_byp_ff ? s1_a_fwd_ff : (s1_a_vld_ff ? ra_data : '0);
   assign opnd_b   = s1_b_byp_ff ? s1_b_fwd_ff : (s1_b_vld_ff ? rb_data : '0);
   assign mem_word = s1_m_byp_ff ? s1_m_fwd_ff : (s1_m_vld_ff ? mem_rd_data : '0);

   assign state.pc      = pc_ff;
   assign state.equal   = flag_ff;
   assign state.stopped = stop_ff;

   cie_alu u_alu (
      .instruction (s1_instr_ff),
      .opnd_a      (opnd_a),
      .opnd_b      (opnd_b),
      .mem_word    (mem_word),
      .state       (state),
      .result      (res)
   );

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         flag_ff      <= 1'b0;
         stop_ff      <= 1'b0;
         reg_vld_ff   <= '0;
         mem_vld_ff   <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (exec_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= res.next_pc;
            flag_ff      <= res.equal_flag;
            stop_ff      <= res.halted;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (reg_we) begin
            reg_vld_ff[res.reg_index] <= 1'b1;
         end
         if (mem_we) begin
            mem_vld_ff[res.mem_addr] <= 1'b1;
         end
      end
   end

   // Capture the input stage and the result register
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_instruction;
         s1_a_byp_ff <= a_byp_in;
         s1_b_byp_ff <= b_byp_in;
         s1_m_byp_ff <= m_byp_in;
         s1_a_fwd_ff <= res.reg_value;
         s1_b_fwd_ff <= res.reg_value;
         s1_m_fwd_ff <= res.mem_data;
         s1_a_vld_ff <= reg_vld_ff[in_ra];
         s1_b_vld_ff <= reg_vld_ff[in_rb];
         s1_m_vld_ff <= mem_vld_ff[in_addr];
      end
      if (exec_fire) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_pc    = rsp_res_ff.next_pc;
   assign rsp_halted     = rsp_res_ff.halted;
   assign rsp_equal_flag = rsp_res_ff.equal_flag;
   assign rsp_reg_write  = rsp_res_ff.reg_write;
   assign rsp_reg_index  = rsp_res_ff.reg_index;
   assign rsp_reg_value  = rsp_res_ff.reg_value;
   assign rsp_mem_write  = rsp_res_ff.mem_write;
   assign rsp_mem_addr   = rsp_res_ff.mem_addr;
   assign rsp_mem_data   = rsp_res_ff.mem_data;

endmodule

// ===== hdl/cie_checker.sv =====
// Port-level assertions for the instruction execute block, bound to the top level.
`timescale 1ns / 1ps

module cie_checker import cie_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [PC_W-1:0]       rsp_next_pc,
   input logic                  rsp_halted,
   input logic                  rsp_equal_flag,
   input logic                  rsp_reg_write,
   input logic [REG_ADDR_W-1:0] rsp_reg_index,
   input logic [WORD_W-1:0]     rsp_reg_value,
   input logic                  rsp_mem_write,
   input logic [MEM_ADDR_W-1:0] rsp_mem_addr,
   input logic [WORD_W-1:0]     rsp_mem_data
);

   logic seen_halt_ff;

   // Remember that a halted result transaction was delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_halt_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_halted) begin
         seen_halt_ff <= 1'b1;
      end
   end

   // Hold a stalled result transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_pc) && $stable(rsp_halted)
         && $stable(rsp_equal_flag) && $stable(rsp_reg_write) && $stable(rsp_reg_index)
         && $stable(rsp_reg_value) && $stable(rsp_mem_write) && $stable(rsp_mem_addr)
         && $stable(rsp_mem_data))
      else $error("stalled result changed");

   // Drop any result out of reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Once halted, stay halted and write nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_halt_ff |-> rsp_halted && !rsp_reg_write && !rsp_mem_write)
      else $error("activity after halt");

   // Zero write fields that are not in use
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reg_write || (rsp_reg_index == '0 && rsp_reg_value == '0))
         && (rsp_mem_write || (rsp_mem_addr == '0 && rsp_mem_data == '0)))
      else $error("unused write field not zero");

endmodule

bind cpu16_instruction_execute cie_checker u_cie_checker (.*);
